@@ src/fimd_pkg.sv @@
// shared types and constants for the flux interval mfm decoder
// no dependencies; imported by flux_interval_mfm_decoder_top
package fimd_pkg;

    // byte address counter width; byte_address carries its low 16 bits
    localparam int ADDR_W = 16;

    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int LIMIT_W   = 8;
    localparam int BYTE_W    = 8;
    localparam int OUT_ADDR_W = 16;
    localparam int CNT_W     = 4;
    // assembly holds up to one byte plus one spill bit
    localparam int ASM_W     = BYTE_W + 1;

    localparam logic [LIMIT_W-1:0] RST_LIMIT_TOO_SHORT = 8'h2D;
    localparam logic [LIMIT_W-1:0] RST_LIMIT_SHORT     = 8'h4D;
    localparam logic [LIMIT_W-1:0] RST_LIMIT_MEDIUM    = 8'h6D;
    localparam logic [LIMIT_W-1:0] RST_LIMIT_LONG      = 8'h8D;

    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_END    = 2'd2,
        CMD_NONE   = 2'd3
    } t_command;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT_TOO_SHORT = 2'd0,
        CFG_LIMIT_SHORT     = 2'd1,
        CFG_LIMIT_MEDIUM    = 2'd2,
        CFG_LIMIT_LONG      = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        CLS_SHORT   = 2'd0,
        CLS_MEDIUM  = 2'd1,
        CLS_LONG    = 2'd2,
        CLS_INVALID = 2'd3
    } t_flux_class;

endpackage

@@ src/flux_interval_mfm_decoder_top.sv @@
// flux interval mfm decoder: intervals in, packed data bytes with addresses out
// depends on fimd_pkg
//
// output: an accepted item's byte is on the output register in the cycle after it is accepted
// throughput: one item per cycle; the output register is the only stage and a
// new item is taken whenever it is empty or being drained in the same cycle
// reset: synchronous active low; clears session, bit assembly, address counter
// and output valid, loads the four limit registers with their defaults and
// holds input ready low
module flux_interval_mfm_decoder_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [fimd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fimd_pkg::LIMIT_W-1:0]    i_cfg_data,
    // input item stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,  // start_address[15:0], interval[23:16]
    input  logic [fimd_pkg::CMD_W-1:0]      s_axis_tuser,  // command[1:0]
    // result item stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,  // byte_value[7:0], byte_address[23:8]
    output logic                            m_axis_tuser   // partial_byte[0]
);
    import fimd_pkg::*;

    // threshold registers
    logic [LIMIT_W-1:0] r_limit_too_short;
    logic [LIMIT_W-1:0] r_limit_short;
    logic [LIMIT_W-1:0] r_limit_medium;
    logic [LIMIT_W-1:0] r_limit_long;

    // decoder state
    logic               r_active;
    logic               r_prev_bit;
    logic [CNT_W-1:0]   r_bit_cnt;
    logic [ASM_W-1:0]   r_asm;
    logic [ADDR_W-1:0]  r_next_addr;

    logic               n_active;
    logic               n_prev_bit;
    logic [CNT_W-1:0]   n_bit_cnt;
    logic [ASM_W-1:0]   n_asm;
    logic [ADDR_W-1:0]  n_next_addr;

    // output register
    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_out_value;
    logic [OUT_ADDR_W-1:0] r_out_addr;
    logic                  r_out_partial;

    logic                  n_emit;
    logic [BYTE_W-1:0]     n_out_value;
    logic                  n_out_partial;

    // input field unpacking
    t_command           in_cmd;
    logic [15:0]        in_start_addr;
    logic [LIMIT_W-1:0] in_interval;

    t_flux_class        flux_cls;
    logic               in_fire;

    // sample decode intermediates
    logic [1:0]         bits_added;
    logic               set_one;
    logic               one_at_next;
    logic               dec_prev;
    logic [ASM_W-1:0]   asm_set;
    logic [CNT_W-1:0]   cnt_sum;

    assign in_cmd        = t_command'(s_axis_tuser);
    assign in_start_addr = s_axis_tdata[15:0];
    assign in_interval   = s_axis_tdata[23:16];

    // take an item out of reset whenever the output register is free or drains this cycle
    assign s_axis_tready = i_rst_n && (!r_out_valid || m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // config writes; the user must issue them only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_too_short <= RST_LIMIT_TOO_SHORT;
            r_limit_short     <= RST_LIMIT_SHORT;
            r_limit_medium    <= RST_LIMIT_MEDIUM;
            r_limit_long      <= RST_LIMIT_LONG;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_LIMIT_TOO_SHORT: r_limit_too_short <= i_cfg_data;
                CFG_LIMIT_SHORT:     r_limit_short     <= i_cfg_data;
                CFG_LIMIT_MEDIUM:    r_limit_medium    <= i_cfg_data;
                CFG_LIMIT_LONG:      r_limit_long      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // interval classification, tests in fixed order so unordered limits still work
    always_comb begin
        priority if (in_interval < r_limit_too_short) flux_cls = CLS_INVALID;
        else if (in_interval < r_limit_short)         flux_cls = CLS_SHORT;
        else if (in_interval < r_limit_medium)        flux_cls = CLS_MEDIUM;
        else if (in_interval < r_limit_long)          flux_cls = CLS_LONG;
        else                                          flux_cls = CLS_INVALID;
    end

    // mfm decode keyed by previous bit and interval class
    always_comb begin
        bits_added  = 2'd1;
        set_one     = 1'b0;
        one_at_next = 1'b0;
        dec_prev    = 1'b0;
        unique case ({r_prev_bit, flux_cls})
            {1'b1, CLS_MEDIUM}: begin
                // two zeros
                bits_added = 2'd2;
            end
            {1'b1, CLS_LONG}: begin
                // zero then one
                bits_added  = 2'd2;
                set_one     = 1'b1;
                one_at_next = 1'b1;
                dec_prev    = 1'b1;
            end
            {1'b0, CLS_MEDIUM},
            {1'b1, CLS_SHORT}: begin
                // single one
                set_one  = 1'b1;
                dec_prev = 1'b1;
            end
            default: begin
                // single zero, also covers invalid intervals
                bits_added = 2'd1;
            end
        endcase

        asm_set = r_asm;
        if (set_one) begin
            // count stays below a byte here, so position fits the spill bit
            asm_set[r_bit_cnt + CNT_W'(one_at_next)] = 1'b1;
        end
        cnt_sum = r_bit_cnt + CNT_W'(bits_added);
    end

    // next state and result selection
    always_comb begin
        n_active      = r_active;
        n_prev_bit    = r_prev_bit;
        n_bit_cnt     = r_bit_cnt;
        n_asm         = r_asm;
        n_next_addr   = r_next_addr;
        n_emit        = 1'b0;
        n_out_value   = r_asm[BYTE_W-1:0];
        n_out_partial = 1'b0;

        if (in_fire) begin
            unique case (in_cmd)
                CMD_START: begin
                    // restart drops any pending bits
                    n_active    = 1'b1;
                    n_prev_bit  = 1'b0;
                    n_bit_cnt   = '0;
                    n_asm       = '0;
                    n_next_addr = ADDR_W'(in_start_addr);
                end
                CMD_SAMPLE: begin
                    if (r_active) begin
                        n_prev_bit = dec_prev;
                        if (cnt_sum >= CNT_W'(BYTE_W)) begin
                            n_emit      = 1'b1;
                            n_out_value = asm_set[BYTE_W-1:0];
                            n_bit_cnt   = cnt_sum - CNT_W'(BYTE_W);
                            n_asm       = ASM_W'(asm_set[ASM_W-1:BYTE_W]);
                            n_next_addr = r_next_addr + ADDR_W'(1);
                        end else begin
                            n_bit_cnt = cnt_sum;
                            n_asm     = asm_set;
                        end
                    end
                end
                CMD_END: begin
                    if (r_active) begin
                        if (r_bit_cnt != '0) begin
                            n_emit        = 1'b1;
                            n_out_partial = 1'b1;
                            n_next_addr   = r_next_addr + ADDR_W'(1);
                        end
                        n_active   = 1'b0;
                        n_prev_bit = 1'b0;
                        n_bit_cnt  = '0;
                        n_asm      = '0;
                    end
                end
                default: ;  // unused command code, ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_prev_bit  <= 1'b0;
            r_bit_cnt   <= '0;
            r_asm       <= '0;
            r_next_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_prev_bit  <= n_prev_bit;
            r_bit_cnt   <= n_bit_cnt;
            r_asm       <= n_asm;
            r_next_addr <= n_next_addr;
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with the address before it advances
    always_ff @(posedge i_clk) begin
        if (n_emit) begin
            r_out_value   <= n_out_value;
            r_out_addr    <= OUT_ADDR_W'(r_next_addr);
            r_out_partial <= n_out_partial;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_addr, r_out_value};
    assign m_axis_tuser  = r_out_partial;

    // pending bit count never holds a full byte between items
    a_cnt_below_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt < CNT_W'(BYTE_W))
        else $error("bit count reached a full byte");

    // outside a session nothing is pending
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_bit_cnt == '0 && r_asm == '0 && !r_prev_bit))
        else $error("pending decode state outside a session");

    // a byte is never produced while the previous one is stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_emit |-> !(r_out_valid && !m_axis_tready))
        else $error("result overwritten while stalled");

    // a partial byte closes the session
    a_partial_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_emit && n_out_partial) |=> !r_active)
        else $error("session still open after flush");

endmodule
